FILE: rtl/mtty_pkg.sv
// ----------------------------------------------------------------------------
// mtty_pkg
// Shared codes and types for the console port with DMA and receive FIFO.
// ----------------------------------------------------------------------------
package mtty_pkg;

  // Item kinds on the input channel
  localparam logic [2:0] CMD_BUS_RD  = 3'd0;
  localparam logic [2:0] CMD_BUS_WR  = 3'd1;
  localparam logic [2:0] CMD_RX_BYTE = 3'd2;
  localparam logic [2:0] CMD_MEM_DAT = 3'd3;
  localparam logic [2:0] CMD_STEP    = 3'd4;

  // Register offsets
  localparam logic [5:0] OFF_PUT_CHAR = 6'h00;
  localparam logic [5:0] OFF_BYTES    = 6'h04;
  localparam logic [5:0] OFF_COMMAND  = 6'h08;
  localparam logic [5:0] OFF_PTR_LO   = 6'h10;
  localparam logic [5:0] OFF_LEN      = 6'h14;
  localparam logic [5:0] OFF_PTR_HI   = 6'h18;
  localparam logic [5:0] OFF_VERSION  = 6'h20;

  // Command numbers written to the command register
  localparam logic [31:0] OP_IRQ_DIS = 32'h0;
  localparam logic [31:0] OP_IRQ_EN  = 32'h1;
  localparam logic [31:0] OP_DMA_TX  = 32'h2;
  localparam logic [31:0] OP_DMA_RX  = 32'h3;

  localparam logic [31:0] VERSION = 32'h1;

  // DMA job state
  localparam logic [1:0] JOB_IDLE = 2'd0;
  localparam logic [1:0] JOB_TX   = 2'd2;
  localparam logic [1:0] JOB_RX   = 2'd3;

  // Queue control from the register logic to the receive queue
  typedef struct packed {
    logic push;
    logic pop;
  } mtty_q_ctl_t;

endpackage

FILE: rtl/mtty_ram.sv
// ----------------------------------------------------------------------------
// mtty_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mtty_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mtty_rxq.sv
// ----------------------------------------------------------------------------
// mtty_rxq
// Receive queue: head and count registers around the byte store RAM.
// ----------------------------------------------------------------------------
module mtty_rxq
  import mtty_pkg::*;
#(
  parameter int FIFO_DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mtty_q_ctl_t                      ctl,
  input  logic [7:0]                       push_byte,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]  count,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]  count_nxt,
  output logic [7:0]                       pop_byte
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(FIFO_DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r;
  logic [CW:0]   pos_sum;
  logic [CW:0]   pos_wrap;
  logic [AW-1:0] wr_addr;

  // Tail position, wrapped once
  assign pos_sum  = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign pos_wrap = (pos_sum >= DEPTH_S) ? pos_sum - DEPTH_S : pos_sum;
  assign wr_addr  = pos_wrap[AW-1:0];

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt = (head_r == LAST_A) ? '0 : head_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

  mtty_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (wr_addr),
    .wdata (push_byte),
    .re    (ctl.pop),
    .raddr (head_r),
    .rdata (pop_byte)
  );

endmodule

FILE: rtl/mmio_tty_with_dma_and_rx_fifo_top.sv
// ----------------------------------------------------------------------------
// mmio_tty_with_dma_and_rx_fifo_top
// Console port with 32-bit register window, receive FIFO and byte DMA.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns exactly one result item for
// each, one register stage deep: at the accepting edge all register state
// (interrupt, DMA pointer and length, job address and remaining count, FIFO
// head and count) is updated and the result is loaded into the output
// register; the FIFO store is a RAM with a registered read, so the byte that
// a receive DMA step pops appears on out_mem_wdata straight from the RAM read
// register together with that result. in_ready is high whenever the output
// register is empty or is being drained in the same cycle, so a stream of
// items runs at one per cycle as long as the result side takes one per cycle.
// out_valid rises in the cycle after the accept. No clearing pass is needed
// after reset: only entries counted in the FIFO are ever read.
// ----------------------------------------------------------------------------
module mmio_tty_with_dma_and_rx_fifo_top
  import mtty_pkg::*;
#(
  parameter int FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_reg_offset,
  input  logic [31:0] in_wdata,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_mem_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_rdata,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_out,
  output logic        out_mem_rd_req,
  output logic        out_mem_wr_req,
  output logic [63:0] out_mem_addr,
  output logic [7:0]  out_mem_wdata,
  output logic        out_irq,
  output logic        out_busy_res,
  output logic [7:0]  out_rx_free,
  output logic        out_rx_overflow
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

  // Control state
  logic        irq_en_r, irq_en_nxt;
  logic        irq_r, irq_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        ovalid_r, ovalid_nxt;
  // Register payload
  logic [63:0] ptr_r, ptr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [63:0] jaddr_r, jaddr_nxt;
  logic [31:0] jrem_r, jrem_nxt;

  // Result register
  logic [31:0] rdata_r, rdata_nxt;
  logic        txv_r, txv_nxt;
  logic [7:0]  txo_r, txo_nxt;
  logic        rd_r, rd_nxt;
  logic        wr_r, wr_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [7:0]  free_r, free_nxt;
  logic        ovf_r, ovf_nxt;

  logic          accept;
  mtty_q_ctl_t   qctl;
  logic [CW-1:0] q_count, q_count_nxt;
  logic [7:0]    q_pop_byte;
  logic [CW-1:0] free_cnt;
  logic [CW+7:0] free_ext;
  logic [CW+31:0] count_ext;
  logic          fifo_full, fifo_empty;

  assign in_ready = !ovalid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign fifo_full  = (q_count == DEPTH_C);
  assign fifo_empty = (q_count == '0);

  // Queue control: push on a received byte with room, pop on a receive step with bytes left and a non-empty FIFO
  always_comb begin
    qctl.push = accept && (in_cmd == CMD_RX_BYTE) && !fifo_full;
    qctl.pop  = accept && (in_cmd == CMD_STEP) && (kind_r == JOB_RX) &&
                (jrem_r != '0) && !fifo_empty;
  end

  assign free_cnt  = DEPTH_C - q_count_nxt;
  assign free_ext  = {8'b0, free_cnt};
  assign count_ext = {32'b0, q_count};

  always_comb begin
    irq_en_nxt = irq_en_r;
    irq_nxt    = irq_r;
    kind_nxt   = kind_r;
    ptr_nxt    = ptr_r;
    len_nxt    = len_r;
    jaddr_nxt  = jaddr_r;
    jrem_nxt   = jrem_r;
    rdata_nxt  = '0;
    txv_nxt    = 1'b0;
    txo_nxt    = '0;
    rd_nxt     = 1'b0;
    wr_nxt     = 1'b0;
    addr_nxt   = '0;
    ovf_nxt    = 1'b0;
    case (in_cmd)
      CMD_BUS_RD: begin
        if (in_reg_offset == OFF_BYTES) begin
          rdata_nxt = count_ext[31:0];
        end else if (in_reg_offset == OFF_VERSION) begin
          rdata_nxt = VERSION;
        end
      end
      CMD_BUS_WR: begin
        // Drop all register writes while a job runs
        if (kind_r == JOB_IDLE) begin
          case (in_reg_offset)
            OFF_PUT_CHAR: begin
              txv_nxt = 1'b1;
              txo_nxt = in_wdata[7:0];
            end
            OFF_COMMAND: begin
              case (in_wdata)
                OP_IRQ_DIS: begin
                  if (irq_en_r) begin
                    if (!fifo_empty) begin
                      irq_nxt = 1'b0;
                    end
                    irq_en_nxt = 1'b0;
                  end
                end
                OP_IRQ_EN: begin
                  if (!irq_en_r) begin
                    if (!fifo_empty) begin
                      irq_nxt = 1'b1;
                    end
                    irq_en_nxt = 1'b1;
                  end
                end
                OP_DMA_TX: begin
                  jaddr_nxt = ptr_r;
                  jrem_nxt  = len_r;
                  kind_nxt  = (len_r != '0) ? JOB_TX : JOB_IDLE;
                end
                OP_DMA_RX: begin
                  jaddr_nxt = ptr_r;
                  jrem_nxt  = len_r;
                  if (len_r == '0 || fifo_empty) begin
                    kind_nxt = JOB_IDLE;
                    if (irq_en_r && fifo_empty) begin
                      irq_nxt = 1'b0;
                    end
                  end else begin
                    kind_nxt = JOB_RX;
                  end
                end
                default: begin
                end
              endcase
            end
            OFF_PTR_LO: ptr_nxt = {32'b0, in_wdata};
            OFF_PTR_HI: ptr_nxt = {in_wdata, ptr_r[31:0]};
            OFF_LEN:    len_nxt = in_wdata;
            default: begin
            end
          endcase
        end
      end
      CMD_RX_BYTE: begin
        ovf_nxt = fifo_full;
        // FIFO is never empty after a received byte
        if (irq_en_r) begin
          irq_nxt = 1'b1;
        end
      end
      CMD_MEM_DAT: begin
        txv_nxt = 1'b1;
        txo_nxt = in_mem_byte;
      end
      CMD_STEP: begin
        if (kind_r == JOB_TX) begin
          if (jrem_r != '0) begin
            rd_nxt    = 1'b1;
            addr_nxt  = jaddr_r;
            jaddr_nxt = jaddr_r + 64'd1;
            jrem_nxt  = jrem_r - 32'd1;
          end
          if (jrem_r <= 32'd1) begin
            kind_nxt = JOB_IDLE;
          end
        end else if (kind_r == JOB_RX) begin
          if (qctl.pop) begin
            wr_nxt    = 1'b1;
            addr_nxt  = jaddr_r;
            jaddr_nxt = jaddr_r + 64'd1;
            jrem_nxt  = jrem_r - 32'd1;
          end
          if (jrem_nxt == '0 || q_count_nxt == '0) begin
            kind_nxt = JOB_IDLE;
            if (irq_en_r && q_count_nxt == '0) begin
              irq_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    free_nxt = free_ext[7:0];
  end

  assign ovalid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_en_r <= 1'b0;
      irq_r    <= 1'b0;
      kind_r   <= JOB_IDLE;
      ovalid_r <= 1'b0;
      ptr_r    <= '0;
      len_r    <= '0;
      jaddr_r  <= '0;
      jrem_r   <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (accept) begin
        irq_en_r <= irq_en_nxt;
        irq_r    <= irq_nxt;
        kind_r   <= kind_nxt;
        ptr_r    <= ptr_nxt;
        len_r    <= len_nxt;
        jaddr_r  <= jaddr_nxt;
        jrem_r   <= jrem_nxt;
      end
    end
  end

  // Result register: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= rdata_nxt;
      txv_r   <= txv_nxt;
      txo_r   <= txo_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      addr_r  <= addr_nxt;
      free_r  <= free_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  mtty_rxq #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_rxq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (qctl),
    .push_byte (in_rx_byte),
    .count     (q_count),
    .count_nxt (q_count_nxt),
    .pop_byte  (q_pop_byte)
  );

  // Interrupt and busy are read from the registers after the item; they
  // only change on accept, so they hold with the rest of the result.
  assign out_valid       = ovalid_r;
  assign out_rdata       = rdata_r;
  assign out_tx_valid    = txv_r;
  assign out_tx_out      = txo_r;
  assign out_mem_rd_req  = rd_r;
  assign out_mem_wr_req  = wr_r;
  assign out_mem_addr    = addr_r;
  assign out_mem_wdata   = wr_r ? q_pop_byte : 8'h00;
  assign out_irq         = irq_r;
  assign out_busy_res    = (kind_r != JOB_IDLE);
  assign out_rx_free     = free_r;
  assign out_rx_overflow = ovf_r;

endmodule

FILE: rtl/mtty_checker.sv
// ----------------------------------------------------------------------------
// mtty_checker
// Port-level checks for the console port, bound to the top level.
// ----------------------------------------------------------------------------
module mtty_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_rdata,
  input logic        out_tx_valid,
  input logic [7:0]  out_tx_out,
  input logic        out_mem_rd_req,
  input logic        out_mem_wr_req,
  input logic [7:0]  out_mem_wdata,
  input logic [7:0]  out_rx_free,
  input logic        out_rx_overflow
);

  // A dropped byte only happens on a full FIFO
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_overflow |-> out_rx_free == 8'h00)
    else $error("overflow flagged with free FIFO entries");

  // A step issues at most one memory request
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_mem_rd_req && out_mem_wr_req))
    else $error("read and write request in one result");

  // Idle link and write data lanes read as zero
  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_out == 8'h00)
    else $error("tx byte without tx_valid");

  a_wd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mem_wr_req |-> out_mem_wdata == 8'h00)
    else $error("write data without write request");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rdata) &&
      $stable(out_mem_wdata))
    else $error("result changed while stalled");

endmodule

bind mmio_tty_with_dma_and_rx_fifo_top mtty_checker u_mtty_checker (.*);
